FILE: rtl/rot_seg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rot_seg_pkg
// Shared types, register codes and fixed-point widths for the segment
// rotation block.
// ----------------------------------------------------------------------------
package rot_seg_pkg;

    // coordinate and trig formats
    localparam int COORD_W        = 16;
    localparam int TRIG_FRAC_BITS = 16;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int CFG_IDX_W      = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_ANGLE_UNITS = 2'd2
    } t_cfg_reg;

    // one input segment
    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic        [7:0]         tag;
        logic                      final_segment;
    } t_seg_in;

    // one rotated segment
    typedef struct packed {
        logic signed [COORD_W-1:0] rot_start_x;
        logic signed [COORD_W-1:0] rot_start_y;
        logic signed [COORD_W-1:0] rot_end_x;
        logic signed [COORD_W-1:0] rot_end_y;
        logic        [7:0]         out_tag;
        logic                      out_final;
    } t_seg_out;

    // angle write into the trig unit
    typedef struct packed {
        logic               we;
        logic [COORD_W-1:0] value;
    } t_angle_wr;

    // trig unit status and results
    typedef struct packed {
        logic                     busy;
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
    } t_trig;

endpackage

FILE: rtl/rot_seg_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rot_seg_trig
// Derives cosine and sine of the configured angle in Q1.16 with a Taylor
// series: one shared 32x32 multiplier forms each term and then divides it by
// the factorial step through a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module rot_seg_trig (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rot_seg_pkg::t_angle_wr i_angle_wr,
    output rot_seg_pkg::t_trig     o_trig
);
    import rot_seg_pkg::*;

    localparam int WORK_FRAC    = 30;
    localparam int TERM_W       = 32;
    localparam int THETA_W      = 31;
    localparam int SUM_W        = 35;
    localparam int REM_W        = 14;
    localparam int DIV_W        = 8;
    localparam int K_W          = 3;
    localparam int ROUND_SH     = WORK_FRAC - TRIG_FRAC_BITS;

    localparam logic [COORD_W-1:0] FULL_TURN_STEPS = 16'd46080;
    localparam logic [COORD_W-1:0] QUARTER_STEPS   = 16'd11520;
    localparam logic [COORD_W-1:0] HALF_STEPS      = 16'd23040;
    localparam logic [COORD_W-1:0] THREE_Q_STEPS   = 16'd34560;
    localparam logic [31:0]        RAD_PER_STEP    = 32'd146409;
    localparam logic [K_W-1:0]     SERIES_TERMS    = 3'd6;
    localparam logic signed [SUM_W-1:0] ONE_Q30    = SUM_W'(1) << WORK_FRAC;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (ROUND_SH - 1);
    localparam logic signed [TRIG_W-1:0] TRIG_ONE  = TRIG_W'(1) << TRIG_FRAC_BITS;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_PREP  = 8'b00000010,
        ST_THETA = 8'b00000100,
        ST_MUL_A = 8'b00001000,
        ST_MUL_B = 8'b00010000,
        ST_DIV   = 8'b00100000,
        ST_FIX   = 8'b01000000,
        ST_ROUND = 8'b10000000
    } t_state;

    // factorial step of the series term
    function automatic logic [DIV_W-1:0] term_div(input logic [K_W-1:0] k,
                                                   input logic cos_sel);
        logic [DIV_W-1:0] d;
        d = 8'd1;
        case (k)
            3'd1:    d = cos_sel ? 8'd2   : 8'd6;
            3'd2:    d = cos_sel ? 8'd12  : 8'd20;
            3'd3:    d = cos_sel ? 8'd30  : 8'd42;
            3'd4:    d = cos_sel ? 8'd56  : 8'd72;
            3'd5:    d = cos_sel ? 8'd90  : 8'd110;
            3'd6:    d = cos_sel ? 8'd132 : 8'd156;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // floor(2^32 / step): the estimated quotient is exact or one low
    function automatic logic [TERM_W-1:0] term_recip(input logic [K_W-1:0] k,
                                                      input logic cos_sel);
        logic [TERM_W-1:0] m;
        m = 32'hFFFF_FFFF;
        case (k)
            3'd1:    m = cos_sel ? 32'd2147483648 : 32'd715827882;
            3'd2:    m = cos_sel ? 32'd357913941  : 32'd214748364;
            3'd3:    m = cos_sel ? 32'd143165576  : 32'd102261126;
            3'd4:    m = cos_sel ? 32'd76695844   : 32'd59652323;
            3'd5:    m = cos_sel ? 32'd47721858   : 32'd39045157;
            3'd6:    m = cos_sel ? 32'd32537631   : 32'd27531841;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    t_state                    r_state;
    logic [K_W-1:0]            r_k;
    logic                      r_cos_sel;
    logic signed [TRIG_W-1:0]  r_cos;
    logic signed [TRIG_W-1:0]  r_sin;

    logic [COORD_W-1:0]        r_angle;
    logic [1:0]                r_quad;
    logic [REM_W-1:0]          r_rem_ang;
    logic [THETA_W-1:0]        r_theta;
    logic [TERM_W-1:0]         r_ts;
    logic [TERM_W-1:0]         r_tc;
    logic signed [SUM_W-1:0]   r_ssum;
    logic signed [SUM_W-1:0]   r_csum;
    logic [TERM_W-1:0]         r_mid;
    logic [TERM_W-1:0]         r_div_q;
    logic [TERM_W-1:0]         r_quo;

    logic [COORD_W-1:0]        n_angle;
    logic [31:0]               theta_prod;
    logic [TERM_W-1:0]         mul_a;
    logic [TERM_W-1:0]         mul_b;
    logic [2*TERM_W-1:0]       mul_p;
    logic [TERM_W-1:0]         mul_hi;
    logic [TERM_W-1:0]         recip_q;
    logic [DIV_W-1:0]          div_d;
    logic [TERM_W-1:0]         qd_prod;
    logic [TERM_W-1:0]         fix_rem;
    logic                      fix_ge;
    logic [TERM_W-1:0]         quo_fix;
    logic signed [SUM_W-1:0]   term_ext;
    logic signed [SUM_W-1:0]   sum_sel;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0]   s_shift;
    logic signed [SUM_W-1:0]   c_shift;
    logic signed [TRIG_W-1:0]  s_round;
    logic signed [TRIG_W-1:0]  c_round;

    // angle reduced to one turn on write
    assign n_angle = (i_angle_wr.value >= FULL_TURN_STEPS)
                   ? i_angle_wr.value - FULL_TURN_STEPS : i_angle_wr.value;

    // remainder angle to radians in Q2.30
    assign theta_prod = 32'(r_rem_ang) * RAD_PER_STEP;

    // shared multiplier: t*theta, mid*theta, then term times reciprocal
    always_comb begin
        case (r_state)
            ST_MUL_A: mul_a = r_cos_sel ? r_tc : r_ts;
            ST_DIV:   mul_a = r_div_q;
            default:  mul_a = r_mid;
        endcase
    end
    assign mul_b  = (r_state == ST_DIV) ? term_recip(r_k, r_cos_sel) : TERM_W'(r_theta);
    assign mul_p  = (2*TERM_W)'(mul_a) * (2*TERM_W)'(mul_b);
    assign mul_hi = mul_p[WORK_FRAC+TERM_W-1:WORK_FRAC];
    assign recip_q = mul_p[2*TERM_W-1:TERM_W];

    // quotient correction by one compare and subtract
    assign div_d   = term_div(r_k, r_cos_sel);
    assign qd_prod = r_quo * TERM_W'(div_d);
    assign fix_rem = r_div_q - qd_prod;
    assign fix_ge  = (fix_rem >= TERM_W'(div_d));
    assign quo_fix = r_quo + TERM_W'(fix_ge);

    // alternating series accumulate
    assign term_ext = $signed({{(SUM_W-TERM_W){1'b0}}, quo_fix});
    assign sum_sel  = r_cos_sel ? r_csum : r_ssum;
    assign n_sum    = r_k[0] ? (sum_sel - term_ext) : (sum_sel + term_ext);

    // round half up to Q1.16
    assign s_shift = (r_ssum + ROUND_HALF) >>> ROUND_SH;
    assign c_shift = (r_csum + ROUND_HALF) >>> ROUND_SH;
    assign s_round = s_shift[TRIG_W-1:0];
    assign c_round = c_shift[TRIG_W-1:0];

    // sequencer control and trig results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_cos_sel <= 1'b0;
            r_cos     <= TRIG_ONE;
            r_sin     <= '0;
        end else if (i_angle_wr.we) begin
            r_state <= ST_PREP;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_state <= ST_IDLE;
                end
                ST_PREP: begin
                    r_state <= ST_THETA;
                end
                ST_THETA: begin
                    r_k       <= 3'd1;
                    r_cos_sel <= 1'b0;
                    r_state   <= ST_MUL_A;
                end
                ST_MUL_A: begin
                    r_state <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_state <= ST_FIX;
                end
                ST_FIX: begin
                    r_cos_sel <= ~r_cos_sel;
                    if (r_cos_sel && r_k == SERIES_TERMS) begin
                        r_state <= ST_ROUND;
                    end else begin
                        if (r_cos_sel) begin
                            r_k <= r_k + 1'b1;
                        end
                        r_state <= ST_MUL_A;
                    end
                end
                ST_ROUND: begin
                    case (r_quad)
                        2'd1: begin
                            r_cos <= -s_round;
                            r_sin <= c_round;
                        end
                        2'd2: begin
                            r_cos <= -c_round;
                            r_sin <= -s_round;
                        end
                        2'd3: begin
                            r_cos <= s_round;
                            r_sin <= -c_round;
                        end
                        default: begin
                            r_cos <= c_round;
                            r_sin <= s_round;
                        end
                    endcase
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // series datapath
    always_ff @(posedge i_clk) begin
        if (i_angle_wr.we) begin
            r_angle <= n_angle;
        end
        case (r_state)
            ST_PREP: begin
                if (r_angle >= THREE_Q_STEPS) begin
                    r_quad    <= 2'd3;
                    r_rem_ang <= REM_W'(r_angle - THREE_Q_STEPS);
                end else if (r_angle >= HALF_STEPS) begin
                    r_quad    <= 2'd2;
                    r_rem_ang <= REM_W'(r_angle - HALF_STEPS);
                end else if (r_angle >= QUARTER_STEPS) begin
                    r_quad    <= 2'd1;
                    r_rem_ang <= REM_W'(r_angle - QUARTER_STEPS);
                end else begin
                    r_quad    <= 2'd0;
                    r_rem_ang <= REM_W'(r_angle);
                end
            end
            ST_THETA: begin
                r_theta <= theta_prod[THETA_W-1:0];
                r_ts    <= TERM_W'(theta_prod[THETA_W-1:0]);
                r_tc    <= TERM_W'(ONE_Q30);
                r_ssum  <= $signed({{(SUM_W-THETA_W){1'b0}}, theta_prod[THETA_W-1:0]});
                r_csum  <= ONE_Q30;
            end
            ST_MUL_A: begin
                r_mid <= mul_hi;
            end
            ST_MUL_B: begin
                r_div_q <= mul_hi;
            end
            ST_DIV: begin
                r_quo <= recip_q;
            end
            ST_FIX: begin
                if (r_cos_sel) begin
                    r_tc   <= quo_fix;
                    r_csum <= n_sum;
                end else begin
                    r_ts   <= quo_fix;
                    r_ssum <= n_sum;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_trig.busy  = (r_state != ST_IDLE);
    assign o_trig.cos_q = r_cos;
    assign o_trig.sin_q = r_sin;

    // an angle write always holds off new segments
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_angle_wr.we |=> o_trig.busy)
        else $error("trig unit not busy after angle write");

    // reciprocal estimate is at most one below the true quotient
    a_quo_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX) |-> (fix_rem < TERM_W'({div_d, 1'b0})))
        else $error("reciprocal quotient estimate out of range");

    // published trig values stay within unit magnitude
    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cos <= TRIG_ONE && r_cos >= -TRIG_ONE &&
                                   r_sin <= TRIG_ONE && r_sin >= -TRIG_ONE))
        else $error("trig value beyond unit magnitude");

endmodule

FILE: rtl/rot_seg_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rot_seg_rotate
// Three-stage rotation datapath: centre offsets, eight parallel 18x17
// products, then sum, round, re-centre and saturate into the result register.
// ----------------------------------------------------------------------------
module rot_seg_rotate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  rot_seg_pkg::t_seg_in          i_item,
    input  logic signed [15:0]            i_center_x,
    input  logic signed [15:0]            i_center_y,
    input  rot_seg_pkg::t_trig            i_trig,
    output logic                          o_strobe,
    output rot_seg_pkg::t_seg_out         o_result
);
    import rot_seg_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = TRIG_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SH_W   = SUM_W - TRIG_FRAC_BITS;
    localparam int OUT_W  = SH_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [OUT_W-1:0] COORD_MAX  = OUT_W'(32767);
    localparam logic signed [OUT_W-1:0] COORD_MIN  = -OUT_W'(32768);

    // round half up, re-centre and clamp to Q12.4
    function automatic logic signed [COORD_W-1:0] finish_coord(
        input logic signed [SUM_W-1:0]   prod,
        input logic signed [COORD_W-1:0] centre);
        logic signed [SUM_W-1:0] shifted;
        logic signed [OUT_W-1:0] v;
        logic signed [COORD_W-1:0] res;
        shifted = (prod + ROUND_HALF) >>> TRIG_FRAC_BITS;
        v = OUT_W'($signed(shifted[SH_W-1:0])) + OUT_W'(centre);
        if (v > COORD_MAX) begin
            res = 16'sh7FFF;
        end else if (v < COORD_MIN) begin
            res = 16'sh8000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    logic                     r_s1_vld;
    logic signed [DIFF_W-1:0] r_s1_dx0;
    logic signed [DIFF_W-1:0] r_s1_dy0;
    logic signed [DIFF_W-1:0] r_s1_dx1;
    logic signed [DIFF_W-1:0] r_s1_dy1;
    logic [7:0]               r_s1_tag;
    logic                     r_s1_final;

    logic                     r_s2_vld;
    logic signed [PROD_W-1:0] r_s2_cdx0;
    logic signed [PROD_W-1:0] r_s2_sdy0;
    logic signed [PROD_W-1:0] r_s2_sdx0;
    logic signed [PROD_W-1:0] r_s2_cdy0;
    logic signed [PROD_W-1:0] r_s2_cdx1;
    logic signed [PROD_W-1:0] r_s2_sdy1;
    logic signed [PROD_W-1:0] r_s2_sdx1;
    logic signed [PROD_W-1:0] r_s2_cdy1;
    logic [7:0]               r_s2_tag;
    logic                     r_s2_final;

    logic                     r_out_vld;
    t_seg_out                 r_out;

    logic signed [SUM_W-1:0]  sum_x0;
    logic signed [SUM_W-1:0]  sum_y0;
    logic signed [SUM_W-1:0]  sum_x1;
    logic signed [SUM_W-1:0]  sum_y1;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_accept;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    // stage 1: offsets from the centre
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_dx0   <= DIFF_W'(i_item.start_x) - DIFF_W'(i_center_x);
            r_s1_dy0   <= DIFF_W'(i_item.start_y) - DIFF_W'(i_center_y);
            r_s1_dx1   <= DIFF_W'(i_item.end_x) - DIFF_W'(i_center_x);
            r_s1_dy1   <= DIFF_W'(i_item.end_y) - DIFF_W'(i_center_y);
            r_s1_tag   <= i_item.tag;
            r_s1_final <= i_item.final_segment;
        end
    end

    // stage 2: products with cosine and sine
    always_ff @(posedge i_clk) begin
        r_s2_cdx0  <= i_trig.cos_q * r_s1_dx0;
        r_s2_sdy0  <= i_trig.sin_q * r_s1_dy0;
        r_s2_sdx0  <= i_trig.sin_q * r_s1_dx0;
        r_s2_cdy0  <= i_trig.cos_q * r_s1_dy0;
        r_s2_cdx1  <= i_trig.cos_q * r_s1_dx1;
        r_s2_sdy1  <= i_trig.sin_q * r_s1_dy1;
        r_s2_sdx1  <= i_trig.sin_q * r_s1_dx1;
        r_s2_cdy1  <= i_trig.cos_q * r_s1_dy1;
        r_s2_tag   <= r_s1_tag;
        r_s2_final <= r_s1_final;
    end

    // rotated offsets
    assign sum_x0 = SUM_W'(r_s2_cdx0) - SUM_W'(r_s2_sdy0);
    assign sum_y0 = SUM_W'(r_s2_sdx0) + SUM_W'(r_s2_cdy0);
    assign sum_x1 = SUM_W'(r_s2_cdx1) - SUM_W'(r_s2_sdy1);
    assign sum_y1 = SUM_W'(r_s2_sdx1) + SUM_W'(r_s2_cdy1);

    // stage 3: result register
    always_ff @(posedge i_clk) begin
        r_out.rot_start_x <= finish_coord(sum_x0, i_center_x);
        r_out.rot_start_y <= finish_coord(sum_y0, i_center_y);
        r_out.rot_end_x   <= finish_coord(sum_x1, i_center_x);
        r_out.rot_end_y   <= finish_coord(sum_y1, i_center_y);
        r_out.out_tag     <= r_s2_tag;
        r_out.out_final   <= r_s2_final;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    // every product stage is followed by a result strobe
    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |=> o_strobe)
        else $error("product stage lost a segment");

    // a strobe only follows a segment that was accepted and passed the offset and product stages
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_accept, 3))
        else $error("result strobe without accepted segment");

endmodule

FILE: rtl/rotate_segment_about_point_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_segment_about_point_top
// Rotates both endpoints of a line segment about a configured centre by a
// configured angle; label and last flag pass through.
//
//   channel   ports                                  transfer when
//   -------   ------------------------------------   -----------------------
//   segment   start, busy, i_item                    start high, busy low
//   result    o_strobe, o_result                     o_strobe high (1 cycle)
//   config    i_cfg_we, i_cfg_idx, i_cfg_data        i_cfg_we high
//
// One segment per cycle while busy is low; each result is registered through
// the offset, product and result stages. An angle write keeps busy high while
// the trig unit runs the series: twelve terms, each two passes of the shared
// multiplier, one reciprocal multiply and one correction step, plus setup
// and rounding. After reset the angle is zero and busy is low at once;
// no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module rotate_segment_about_point_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  rot_seg_pkg::t_seg_in              i_item,
    output logic                              o_strobe,
    output rot_seg_pkg::t_seg_out             o_result,
    input  logic                              i_cfg_we,
    input  logic [rot_seg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rot_seg_pkg::COORD_W-1:0]   i_cfg_data
);
    import rot_seg_pkg::*;

    logic signed [COORD_W-1:0] r_center_x;
    logic signed [COORD_W-1:0] r_center_y;
    t_angle_wr                 angle_wr;
    t_trig                     trig;
    logic                      accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X: r_center_x <= $signed(i_cfg_data);
                REG_CENTER_Y: r_center_y <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // angle write goes to the trig unit
    assign angle_wr.we    = i_cfg_we && (i_cfg_idx == REG_ANGLE_UNITS);
    assign angle_wr.value = i_cfg_data;

    rot_seg_trig u_trig (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_angle_wr (angle_wr),
        .o_trig     (trig)
    );

    // segment transfer
    assign busy   = trig.busy;
    assign accept = start && !trig.busy;

    rot_seg_rotate u_rotate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_trig     (trig),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // fixed latency from segment transfer to result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_strobe)
        else $error("result strobe missing three cycles after transfer");

endmodule

FILE: sim/rotate_segment_about_point_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_segment_about_point_top_test
// Self-checking bench for the segment rotation block. A short table of
// directed segments covers identity, quarter turns, angle wrap, saturation
// and extreme centres. Random phases follow, each with a fresh centre,
// angle or both. Every result is checked field by field against typed values
// or a bit-true predictor of the Q1.16 trig series and the rounded, saturated rotation.
// ----------------------------------------------------------------------------
module rotate_segment_about_point_top_test;

    import rot_seg_pkg::*;

    typedef longint unsigned u64_t;

    // trig series constants
    localparam u64_t FULL_TURN    = 46080;
    localparam u64_t QUARTER_TURN = 11520;
    localparam u64_t RAD_PER_STEP = 146409;
    localparam int   WORK_FRAC    = 30;
    localparam int   SERIES_TERMS = 6;

    // coordinate limits
    localparam logic signed [COORD_W-1:0] CMAX = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] CMIN = 16'sh8000;
    localparam longint SAT_HI = 32767;
    localparam longint SAT_LO = -32768;

    // angles in 1/128 degree
    localparam logic [COORD_W-1:0] ANG_0   = 16'd0;
    localparam logic [COORD_W-1:0] ANG_1   = 16'd1;
    localparam logic [COORD_W-1:0] ANG_30  = 16'd3840;
    localparam logic [COORD_W-1:0] ANG_45  = 16'd5760;
    localparam logic [COORD_W-1:0] ANG_90  = 16'd11520;
    localparam logic [COORD_W-1:0] ANG_180 = 16'd23040;
    localparam logic [COORD_W-1:0] ANG_270 = 16'd34560;
    localparam logic [COORD_W-1:0] ANG_TOP = 16'd46079;
    localparam logic [COORD_W-1:0] ANG_360 = 16'd46080;
    localparam logic [COORD_W-1:0] ANG_MAX = 16'hFFFF;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // run shape
    localparam int RAND_PHASES   = 16;
    localparam int PHASE_ITEMS   = 125;
    localparam int QUIET_PHASE   = 3;
    localparam int IDLE_PERCENT  = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int WATCHDOG_NS   = 2_000_000;

    // one directed row: config, segment, and typed result where obvious
    typedef struct packed {
        logic signed [COORD_W-1:0] cx, cy;
        logic        [COORD_W-1:0] angle;
        logic signed [COORD_W-1:0] sx, sy, ex, ey;
        logic        [7:0]         tag;
        logic                      fin;
        logic                      typed;
        logic signed [COORD_W-1:0] wsx, wsy, wex, wey;
    } t_dir_row;

    localparam int DIR_ROWS = 17;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // reset config is the identity
        '{16'sd0, 16'sd0, ANG_0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00, 1'b0,
          1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, ANG_0, CMAX, CMAX, CMAX, CMAX, 8'hFF, 1'b1,
          1'b1, CMAX, CMAX, CMAX, CMAX},
        '{16'sd0, 16'sd0, ANG_0, CMIN, CMIN, CMIN, CMIN, 8'h00, 1'b0,
          1'b1, CMIN, CMIN, CMIN, CMIN},
        '{16'sd0, 16'sd0, ANG_0, CMAX, CMIN, CMIN, CMAX, 8'hA5, 1'b1,
          1'b1, CMAX, CMIN, CMIN, CMAX},
        // quarter turn: x' = -y, y' = x
        '{16'sd0, 16'sd0, ANG_90, 16'sd16, 16'sd32, -16'sd48, 16'sd100, 8'h03, 1'b0,
          1'b1, -16'sd32, 16'sd16, -16'sd100, -16'sd48},
        '{16'sd0, 16'sd0, ANG_90, 16'sd0, CMIN, CMIN, 16'sd0, 8'h5A, 1'b1,
          1'b1, CMAX, 16'sd0, 16'sd0, CMIN},
        // half turn, negating the minimum saturates
        '{16'sd0, 16'sd0, ANG_180, CMIN, CMIN, CMAX, 16'sd100, 8'h80, 1'b0,
          1'b1, CMAX, CMAX, -16'sd32767, -16'sd100},
        // three quarter turn: x' = y, y' = -x
        '{16'sd0, 16'sd0, ANG_270, 16'sd5, 16'sd7, CMIN, 16'sd1, 8'h01, 1'b1,
          1'b1, 16'sd7, -16'sd5, 16'sd1, CMAX},
        // full turn wraps to zero
        '{16'sd0, 16'sd0, ANG_360, 16'sd123, -16'sd456, -16'sd7, 16'sd9, 8'h7E, 1'b0,
          1'b1, 16'sd123, -16'sd456, -16'sd7, 16'sd9},
        // largest raw angle, top of range, smallest step
        '{16'sd0, 16'sd0, ANG_MAX, 16'sd1000, -16'sd2000, CMAX, CMIN, 8'hC3, 1'b1,
          1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, ANG_TOP, 16'sd4096, 16'sd4096, -16'sd4096, CMAX, 8'h3C, 1'b0,
          1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, ANG_1, CMAX, 16'sd0, 16'sd0, CMAX, 8'h11, 1'b1,
          1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        // extreme centre, identity and half turn with saturation
        '{CMAX, CMIN, ANG_0, CMIN, CMAX, CMAX, CMIN, 8'hF0, 1'b0,
          1'b1, CMIN, CMAX, CMAX, CMIN},
        '{CMAX, CMIN, ANG_180, CMIN, CMAX, CMAX, CMIN, 8'h0F, 1'b1,
          1'b1, CMAX, CMIN, CMAX, CMIN},
        // odd angles about other centres
        '{CMIN, CMAX, ANG_45, 16'sd0, 16'sd0, CMAX, CMIN, 8'h42, 1'b0,
          1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{CMIN, CMAX, ANG_45, CMIN, CMAX, -16'sd100, 16'sd200, 8'h24, 1'b1,
          1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd100, -16'sd200, ANG_30, 16'sd300, -16'sd50, -16'sd1000, 16'sd1234,
          8'h99, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
    };

    // block ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_seg_in               i_item;
    logic                  o_strobe;
    t_seg_out              o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [COORD_W-1:0]    i_cfg_data;

    // shadow of the block's configuration and derived trig
    logic signed [COORD_W-1:0] cfg_cx;
    logic signed [COORD_W-1:0] cfg_cy;
    logic        [COORD_W-1:0] cfg_angle;
    longint                    trig_cos;
    longint                    trig_sin;

    // rotated segments still to come, oldest first
    t_seg_out pending_rot [$];

    int  segs_sent;
    int  segs_directed;
    int  segs_checked;
    int  cfg_writes;
    int  mismatch_count;
    bit  allow_idle;

    rotate_segment_about_point_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("%0t: timeout, %0d results still pending", $time, pending_rot.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // cosine and sine in Q1.16 from the truncated taylor series
    function automatic void derive_trig(input logic [COORD_W-1:0] angle_raw);
        u64_t   a, th, ts, tc;
        longint ssum, csum, s_r, c_r;
        int     quad;
        a    = u64_t'(angle_raw) % FULL_TURN;
        quad = int'(a / QUARTER_TURN);
        th   = (a % QUARTER_TURN) * RAD_PER_STEP;
        ts   = th;
        tc   = u64_t'(1) << WORK_FRAC;
        ssum = longint'(ts);
        csum = longint'(tc);
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            ts = ((((ts * th) >> WORK_FRAC) * th) >> WORK_FRAC) / u64_t'((2*k) * (2*k + 1));
            tc = ((((tc * th) >> WORK_FRAC) * th) >> WORK_FRAC) / u64_t'((2*k - 1) * (2*k));
            if (k % 2 == 1) begin
                ssum -= longint'(ts);
                csum -= longint'(tc);
            end else begin
                ssum += longint'(ts);
                csum += longint'(tc);
            end
        end
        // round half up to the trig format
        s_r = (ssum + (longint'(1) << (WORK_FRAC - TRIG_FRAC_BITS - 1)))
              >>> (WORK_FRAC - TRIG_FRAC_BITS);
        c_r = (csum + (longint'(1) << (WORK_FRAC - TRIG_FRAC_BITS - 1)))
              >>> (WORK_FRAC - TRIG_FRAC_BITS);
        // fold back into the quadrant
        case (quad)
            1: begin
                trig_cos = -s_r;
                trig_sin = c_r;
            end
            2: begin
                trig_cos = -c_r;
                trig_sin = -s_r;
            end
            3: begin
                trig_cos = s_r;
                trig_sin = -c_r;
            end
            default: begin
                trig_cos = c_r;
                trig_sin = s_r;
            end
        endcase
    endfunction

    // round the exact offset half up, add the centre, clamp to q12.4
    function automatic logic [COORD_W-1:0] round_sat(input longint prod, input longint centre);
        longint v;
        v = ((prod + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS) + centre;
        if (v > SAT_HI) v = SAT_HI;
        else if (v < SAT_LO) v = SAT_LO;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [2*COORD_W-1:0] rotate_point(input logic signed [COORD_W-1:0] px,
                                                         input logic signed [COORD_W-1:0] py);
        longint dx, dy;
        dx = longint'(px) - longint'(cfg_cx);
        dy = longint'(py) - longint'(cfg_cy);
        return {round_sat(trig_cos * dx - trig_sin * dy, longint'(cfg_cx)),
                round_sat(trig_sin * dx + trig_cos * dy, longint'(cfg_cy))};
    endfunction

    function automatic t_seg_out predict_rotation(input t_seg_in seg);
        t_seg_out r;
        {r.rot_start_x, r.rot_start_y} = rotate_point(seg.start_x, seg.start_y);
        {r.rot_end_x, r.rot_end_y}     = rotate_point(seg.end_x, seg.end_y);
        r.out_tag   = seg.tag;
        r.out_final = seg.final_segment;
        return r;
    endfunction

    function automatic int field_mismatch(input string name, input logic [COORD_W-1:0] want,
                                          input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, $signed(want), $signed(got));
            return 1;
        end
        return 0;
    endfunction

    task automatic check_segment(input t_seg_out want, input t_seg_out got);
        int bad;
        bad = field_mismatch("rot_start_x", want.rot_start_x, got.rot_start_x)
            + field_mismatch("rot_start_y", want.rot_start_y, got.rot_start_y)
            + field_mismatch("rot_end_x", want.rot_end_x, got.rot_end_x)
            + field_mismatch("rot_end_y", want.rot_end_y, got.rot_end_y)
            + field_mismatch("out_tag", {8'h00, want.out_tag}, {8'h00, got.out_tag})
            + field_mismatch("out_final", {15'h0, want.out_final}, {15'h0, got.out_final});
        mismatch_count += bad;
    endtask

    // random stimulus values
    function automatic logic [COORD_W-1:0] rand_coord(input logic signed [COORD_W-1:0] centre);
        longint v;
        case ($urandom_range(9))
            0: return CMAX;
            1: return CMIN;
            2, 3, 4, 5: begin
                // near the centre, so most results stay in range
                v = longint'(centre) + longint'($urandom_range(0, 8191)) - 4096;
                return v[COORD_W-1:0];
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_seg_in random_segment();
        t_seg_in s;
        s.start_x       = rand_coord(cfg_cx);
        s.start_y       = rand_coord(cfg_cy);
        s.end_x         = rand_coord(cfg_cx);
        s.end_y         = rand_coord(cfg_cy);
        s.tag           = 8'($urandom);
        s.final_segment = 1'($urandom);
        return s;
    endfunction

    function automatic logic [COORD_W-1:0] pick_center();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return CMAX;
            2: return CMIN;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_angle();
        case ($urandom_range(9))
            0: return ANG_0;
            1: return ANG_TOP;
            2: return ANG_MAX;
            // around a quadrant boundary
            3: return 16'(u64_t'($urandom_range(0, 4)) * QUARTER_TURN
                          + u64_t'($urandom_range(0, 2)) - 1);
            // raw value past a full turn
            4: return 16'($urandom_range(46080, 65535));
            default: return 16'($urandom_range(0, 46079));
        endcase
    endfunction

    // quiet the segment side and let the block finish its work
    task automatic settle_block();
        start <= 1'b0;
        while (pending_rot.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        settle_block();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_CENTER_X: cfg_cx = data;
            REG_CENTER_Y: cfg_cy = data;
            REG_ANGLE_UNITS: begin
                cfg_angle = data;
                derive_trig(data);
            end
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic pick_config();
        bit wrote;
        wrote = 1'b0;
        if ($urandom_range(3) != 0) begin
            write_reg(REG_CENTER_X, pick_center());
            wrote = 1'b1;
        end
        if ($urandom_range(3) != 0) begin
            write_reg(REG_CENTER_Y, pick_center());
            wrote = 1'b1;
        end
        if (!wrote || $urandom_range(3) != 0) write_reg(REG_ANGLE_UNITS, pick_angle());
        if ($urandom_range(5) == 0) write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // random gap before a segment
    task automatic maybe_idle();
        if (allow_idle && $urandom_range(99) < IDLE_PERCENT) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // hold off until every rotated segment has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_rot.size() != 0);
    endtask

    // one segment transfer, then queue what it must produce
    task automatic send_segment(input t_seg_in seg, input bit typed, input t_seg_out want);
        i_item <= seg;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (typed) pending_rot.push_back(want);
        else pending_rot.push_back(predict_rotation(seg));
        segs_sent++;
    endtask

    // result checker, the receiver never stalls
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_rot.size() == 0) begin
                $display("%0t: result with nothing pending, got %h", $time, o_result);
                mismatch_count++;
            end else begin
                check_segment(pending_rot.pop_front(), o_result);
                segs_checked++;
            end
        end
    end

    // stimulus
    initial begin
        t_dir_row row;
        t_seg_in  seg;
        t_seg_out want;
        int       hold_at;

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        segs_sent      = 0;
        segs_directed  = 0;
        segs_checked   = 0;
        cfg_writes     = 0;
        mismatch_count = 0;
        allow_idle     = 1'b1;
        cfg_cx    = '0;
        cfg_cy    = '0;
        cfg_angle = '0;
        derive_trig(ANG_0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a write to an unused index must leave the identity in place
        write_reg(REG_UNUSED, 16'hFFFF);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIR_TABLE[i];
            if (row.cx != cfg_cx) write_reg(REG_CENTER_X, row.cx);
            if (row.cy != cfg_cy) write_reg(REG_CENTER_Y, row.cy);
            if (row.angle != cfg_angle) write_reg(REG_ANGLE_UNITS, row.angle);
            seg.start_x       = row.sx;
            seg.start_y       = row.sy;
            seg.end_x         = row.ex;
            seg.end_y         = row.ey;
            seg.tag           = row.tag;
            seg.final_segment = row.fin;
            want.rot_start_x  = row.wsx;
            want.rot_start_y  = row.wsy;
            want.rot_end_x    = row.wex;
            want.rot_end_y    = row.wey;
            want.out_tag      = row.tag;
            want.out_final    = row.fin;
            maybe_idle();
            send_segment(seg, row.typed, want);
            segs_directed++;
        end

        // random phases, each under a new setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick_config();
            allow_idle = (ph != QUIET_PHASE);
            hold_at    = $urandom_range(0, PHASE_ITEMS - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == hold_at) drain_results();
                maybe_idle();
                send_segment(random_segment(), 1'b0, '0);
            end
        end

        // wait out the last results
        start <= 1'b0;
        while (pending_rot.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d segments (%0d from the table), %0d results checked",
                 segs_sent, segs_directed, segs_checked);
        $display("%0d config writes over %0d random settings, %0d mismatches",
                 cfg_writes, RAND_PHASES, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/rot_seg_pkg.sv
rtl/rot_seg_trig.sv
rtl/rot_seg_rotate.sv
rtl/rotate_segment_about_point_top.sv
sim/rotate_segment_about_point_top_test.sv
